FILE: rtl/core/lcs_pkg.sv
package lcs_pkg;

	localparam int MAX_TEXT_DEF = 128;
	localparam int MAX_HITS_DEF = 32;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRC,
		S_ROW,
		S_DRAIN,
		S_END,
		S_ERD,
		S_ELD
	} lcs_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic tgt_write;
		logic src_accept;
		logic row_start;
		logic row_step;
		logic row_done;
		logic emit_rd;
		logic emit_ld;
		logic emit_next;
		logic finish;
	} lcs_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic j_last;
		logic tlen_zero;
		logic pos_full;
		logic hits_zero;
		logic k_last;
		logic out_busy;
		logic src_last;
	} lcs_stat_t;

endpackage

FILE: rtl/core/longest_common_substring_all_hits_core.sv
// target symbol: one accepted per cycle while idle
// source symbol: a row sweep, one run-length cell per cycle through the target and row
//   memories; no sweep when the target is empty or the source is full
// results: read from the hit list, each loaded once the output register is free
// reset: asynchronous active-low arst_n, block comes up loading an empty target
module longest_common_substring_all_hits_core import lcs_pkg::*; #(
	parameter int MAX_TEXT = MAX_TEXT_DEF,
	parameter int MAX_HITS = MAX_HITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // symbol[7:0]
	input  logic        s_tuser,  // opcode: 0 target symbol, 1 source symbol
	input  logic        s_tlast,  // last symbol of the string
	output logic        m_tvalid,
	input  logic        m_tready,
	// source_start[6:0], target_start[13:7], match_length[21:14], hit_count[27:22],
	// hit_valid[28], hits_dropped[29], zero[31:30]
	output logic [31:0] m_tdata,
	output logic        m_tlast   // last result of the run
);

	lcs_cmd_t  cmd;
	lcs_stat_t stat;

	// sequencer: input transactions, row sweep and hit emission
	lcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// memories, run-length cell pipeline, hit list and output register
	lcs_dpath #(
		.MAX_TEXT (MAX_TEXT),
		.MAX_HITS (MAX_HITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: rtl/core/lcs_ctrl.sv
module lcs_ctrl import lcs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	input  logic      s_tuser,
	output logic      s_tready,
	input  lcs_stat_t stat,
	output lcs_cmd_t  cmd
);

	lcs_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser) begin
						cmd.src_accept = 1'b1;
						state_d        = S_SRC;
					end else begin
						cmd.tgt_write = 1'b1;
					end
				end
			end
			S_SRC: begin
				if (stat.pos_full) begin
					state_d = S_END;
				end else if (stat.tlen_zero) begin
					cmd.row_done = 1'b1;
					state_d      = S_END;
				end else begin
					cmd.row_start = 1'b1;
					state_d       = S_ROW;
				end
			end
			S_ROW: begin
				cmd.row_step = 1'b1;
				if (stat.j_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				cmd.row_done = 1'b1;
				state_d      = S_END;
			end
			S_END: begin
				state_d = stat.src_last ? S_ERD : S_IDLE;
			end
			S_ERD: begin
				cmd.emit_rd = !stat.hits_zero;
				state_d     = S_ELD;
			end
			S_ELD: begin
				if (!stat.out_busy) begin
					cmd.emit_ld = 1'b1;
					if (stat.hits_zero || stat.k_last) begin
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
					end else begin
						cmd.emit_next = 1'b1;
						state_d       = S_ERD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/core/lcs_dpath.sv
module lcs_dpath import lcs_pkg::*; #(
	parameter int MAX_TEXT = MAX_TEXT_DEF,
	parameter int MAX_HITS = MAX_HITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  lcs_cmd_t    cmd,
	output lcs_stat_t   stat,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  logic        m_tready,
	output logic        m_tvalid,
	output logic [31:0] m_tdata,
	output logic        m_tlast
);

	localparam int IW  = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
	localparam int LW  = $clog2(MAX_TEXT + 1);
	localparam int HW  = $clog2(MAX_HITS + 1);
	localparam int HIW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
	localparam int XW  = (LW > 7) ? LW : 7;
	localparam int MW  = (LW > 8) ? LW : 8;
	localparam int CW  = (HW > 6) ? HW : 6;

	logic [7:0]    tgt_mem [MAX_TEXT];
	logic [LW-1:0] row_mem [MAX_TEXT];
	logic [IW-1:0] hs_mem  [MAX_HITS];
	logic [IW-1:0] ht_mem  [MAX_HITS];

	logic [LW-1:0]  tlen_q, pos_q, best_q, carry_q;
	logic [HW-1:0]  hits_q;
	logic           loading_q, ovf_q, first_q, last_q;
	logic [7:0]     sym_q;
	logic [IW-1:0]  j_q;
	logic [HIW-1:0] k_q;
	logic           valid_s1;
	logic [IW-1:0]  j_s1;
	logic [7:0]     tgt_s1;
	logic [LW-1:0]  old_s1;
	logic [IW-1:0]  hs_rd_q, ht_rd_q;

	logic           out_valid_q, out_last_q;
	logic [31:0]    out_data_q;

	logic [LW-1:0]  eff, old_eff, run, best_n;
	logic           room, match, gt, eq, app;
	logic [HW-1:0]  hits_base;
	logic           ovf_base;
	logic [XW-1:0]  ss_full, ts_full;
	logic [MW-1:0]  ml_full;
	logic [CW-1:0]  hc_full;

	// target write slot, restarting the string when a pair was running
	assign eff  = loading_q ? tlen_q : '0;
	assign room = eff < LW'(MAX_TEXT);

	// diagonal cell update
	assign match     = valid_s1 && (tgt_s1 == sym_q);
	assign old_eff   = first_q ? '0 : old_s1;
	assign run       = match ? (carry_q + LW'(1)) : '0;
	assign gt        = run > best_q;
	assign best_n    = gt ? run : best_q;
	assign hits_base = gt ? '0 : hits_q;
	assign ovf_base  = gt ? 1'b0 : ovf_q;
	assign eq        = match && (run == best_n);
	assign app       = eq && (hits_base < HW'(MAX_HITS));

	assign ss_full = XW'(hs_rd_q) - XW'(best_q) + XW'(1);
	assign ts_full = XW'(ht_rd_q) - XW'(best_q) + XW'(1);
	assign ml_full = MW'(best_q);
	assign hc_full = CW'(hits_q);

	always_ff @(posedge clk) begin
		if (cmd.tgt_write && room) begin
			tgt_mem[eff[IW-1:0]] <= s_tdata;
		end
		if (cmd.row_step) begin
			tgt_s1 <= tgt_mem[j_q];
			old_s1 <= row_mem[j_q];
		end
		if (valid_s1) begin
			row_mem[j_s1] <= run;
		end
		if (app) begin
			hs_mem[hits_base[HIW-1:0]] <= pos_q[IW-1:0];
			ht_mem[hits_base[HIW-1:0]] <= j_s1;
		end
		if (cmd.emit_rd) begin
			hs_rd_q <= hs_mem[k_q];
			ht_rd_q <= ht_mem[k_q];
		end
		j_s1 <= j_q;
		if (cmd.src_accept) begin
			sym_q  <= s_tdata;
		end
		if (cmd.emit_ld) begin
			if (hits_q == '0) begin
				out_data_q <= '0;
				out_last_q <= 1'b1;
			end else begin
				out_data_q <= {2'b00, ovf_q, 1'b1, hc_full[5:0], ml_full[7:0],
					ts_full[6:0], ss_full[6:0]};
				out_last_q <= (HW'(k_q) + HW'(1)) == hits_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlen_q      <= '0;
			loading_q   <= 1'b1;
			pos_q       <= '0;
			best_q      <= '0;
			hits_q      <= '0;
			ovf_q       <= 1'b0;
			first_q     <= 1'b1;
			last_q      <= 1'b0;
			j_q         <= '0;
			carry_q     <= '0;
			k_q         <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= cmd.row_step;
			if (cmd.tgt_write) begin
				tlen_q    <= eff + LW'(room);
				loading_q <= !s_tlast;
				pos_q     <= '0;
				best_q    <= '0;
				hits_q    <= '0;
				ovf_q     <= 1'b0;
				first_q   <= 1'b1;
			end
			if (cmd.src_accept) begin
				last_q    <= s_tlast;
				loading_q <= 1'b0;
				if (loading_q) begin
					pos_q   <= '0;
					best_q  <= '0;
					hits_q  <= '0;
					ovf_q   <= 1'b0;
					first_q <= 1'b1;
				end
			end
			if (cmd.row_start) begin
				j_q     <= '0;
				carry_q <= '0;
			end
			if (cmd.row_step) begin
				j_q <= j_q + IW'(1);
			end
			if (valid_s1) begin
				carry_q <= old_eff;
				if (match) begin
					best_q <= best_n;
					hits_q <= app ? (hits_base + HW'(1)) : hits_base;
					ovf_q  <= ovf_base | (eq & !app);
				end
			end
			if (cmd.row_done) begin
				pos_q   <= pos_q + LW'(1);
				first_q <= 1'b0;
			end
			if (cmd.emit_next) begin
				k_q <= k_q + HIW'(1);
			end
			if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.emit_ld) begin
				out_valid_q <= 1'b1;
			end
			if (cmd.finish) begin
				tlen_q    <= '0;
				loading_q <= 1'b1;
				pos_q     <= '0;
				best_q    <= '0;
				hits_q    <= '0;
				ovf_q     <= 1'b0;
				first_q   <= 1'b1;
				k_q       <= '0;
			end
		end
	end

	assign stat.j_last    = (LW'(j_q) + LW'(1)) == tlen_q;
	assign stat.tlen_zero = tlen_q == '0;
	assign stat.pos_full  = pos_q >= LW'(MAX_TEXT);
	assign stat.hits_zero = hits_q == '0;
	assign stat.k_last    = (HW'(k_q) + HW'(1)) == hits_q;
	assign stat.out_busy  = out_valid_q;
	assign stat.src_last  = last_q;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

FILE: rtl/core/lcs_checker.sv
module lcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tlast
);

	// a stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result dropped while stalled");

	// the empty result is always the only one of its run
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[28] |-> m_tlast && m_tdata[29:0] == 30'd0)
		else $error("empty result malformed");

	// a hit has a nonzero length and count
	a_hit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[28] |-> m_tdata[21:14] != 8'd0 && m_tdata[27:22] != 6'd0)
		else $error("hit with zero length or count");

	// results of one run share length and count
	a_run_same: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast ##1 m_tvalid |->
		m_tdata[27:14] == $past(m_tdata[27:14]))
		else $error("length changed within a run");

endmodule

bind longest_common_substring_all_hits_core lcs_checker u_lcs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
